### rtl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// Reservation station pool package
// Shared widths, operation codes and the item types of both channels.
// ----------------------------------------------------------------------------
package rsp_pkg;

   localparam int RSP_ENTRIES       = 8;
   localparam int RSP_TAG_WIDTH     = 4;
   localparam int RSP_DATA_WIDTH    = 32;
   localparam int RSP_PAYLOAD_WIDTH = 32;

   localparam logic [1:0] OP_WRITE     = 2'd0;
   localparam logic [1:0] OP_BROADCAST = 2'd1;
   localparam logic [1:0] OP_SELECT    = 2'd2;
   localparam logic [1:0] OP_FREE      = 2'd3;

   typedef struct packed {
      logic [1:0]                   op;
      logic [RSP_TAG_WIDTH-1:0]     entry_tag;
      logic                         entry_busy;
      logic [RSP_TAG_WIDTH-1:0]     entry_src1_tag;
      logic [RSP_DATA_WIDTH-1:0]    entry_src1_value;
      logic [RSP_TAG_WIDTH-1:0]     entry_src2_tag;
      logic [RSP_DATA_WIDTH-1:0]    entry_src2_value;
      logic [RSP_PAYLOAD_WIDTH-1:0] entry_payload;
      logic [RSP_TAG_WIDTH-1:0]     bus_tag;
      logic [RSP_DATA_WIDTH-1:0]    bus_value;
   } req_item_type;

   typedef struct packed {
      logic                         accepted;
      logic [RSP_TAG_WIDTH-1:0]     free_tag;
      logic                         all_empty;
      logic [RSP_TAG_WIDTH-1:0]     ready_tag;
      logic [RSP_DATA_WIDTH-1:0]    ready_src1_value;
      logic [RSP_DATA_WIDTH-1:0]    ready_src2_value;
      logic [RSP_PAYLOAD_WIDTH-1:0] ready_payload;
   } rsp_item_type;

endpackage

### rtl/reservation_station_pool_top.sv
// ----------------------------------------------------------------------------
// Reservation station pool top level
// Registers each item, applies it to the entry pool and registers the result.
// ----------------------------------------------------------------------------
// An item is taken whenever start is high and busy is low, one item every
// cycle; busy is high only around reset. Each item gives exactly one result,
// shown on the rsp_ ports for one cycle under rsp_strobe once the item has
// passed the input register and then the pool logic into the result
// register. The receiver cannot stall, so results leave in item order at the
// rate items arrive.
module reservation_station_pool_top
   import rsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_strobe,
   output rsp_item_type rsp_item
);

   logic         busy_ff;
   logic         in_valid_ff;
   req_item_type in_item_ff;
   logic         out_valid_ff;
   rsp_item_type out_item_ff;
   rsp_item_type pool_result;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         in_valid_ff  <= start && !busy_ff;
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff  <= req_item;
      out_item_ff <= pool_result;
   end

   rsp_pool u_pool (
      .clock     (clock),
      .reset     (reset),
      .item_valid(in_valid_ff),
      .item      (in_item_ff),
      .result    (pool_result)
   );

   assign busy       = busy_ff;
   assign rsp_strobe = out_valid_ff;
   assign rsp_item   = out_item_ff;

`ifndef ASSERT_OFF
   a_result_follows_item: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("An accepted item produced no result.");

   a_empty_means_first_free: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.all_empty) |-> (rsp_item.free_tag == RSP_TAG_WIDTH'(1)))
      else $error("Empty pool reported a free tag other than the first.");

   a_select_accepted: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_item.ready_tag != '0)) |-> rsp_item.accepted)
      else $error("A selected entry was reported without acceptance.");

   a_strobe_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(in_valid_ff))
      else $error("A result appeared without an item in the input register.");
`endif

endmodule

### rtl/rsp_pool.sv
// ----------------------------------------------------------------------------
// Reservation station entry pool
// Holds the entries and performs one write, broadcast, select or free per
// cycle with item_valid high, giving that item's result combinationally.
// ----------------------------------------------------------------------------
module rsp_pool
   import rsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         item_valid,
   input  req_item_type item,
   output rsp_item_type result
);

   localparam int ENTRIES = RSP_ENTRIES;
   localparam logic [RSP_TAG_WIDTH-1:0] MAX_TAG = RSP_TAG_WIDTH'(ENTRIES);

   logic [ENTRIES-1:0]           busy_ff;
   logic [ENTRIES-1:0]           busy_in;
   logic [RSP_TAG_WIDTH-1:0]     src1_tag_ff   [ENTRIES];
   logic [RSP_TAG_WIDTH-1:0]     src1_tag_in   [ENTRIES];
   logic [RSP_DATA_WIDTH-1:0]    src1_value_ff [ENTRIES];
   logic [RSP_DATA_WIDTH-1:0]    src1_value_in [ENTRIES];
   logic [RSP_TAG_WIDTH-1:0]     src2_tag_ff   [ENTRIES];
   logic [RSP_TAG_WIDTH-1:0]     src2_tag_in   [ENTRIES];
   logic [RSP_DATA_WIDTH-1:0]    src2_value_ff [ENTRIES];
   logic [RSP_DATA_WIDTH-1:0]    src2_value_in [ENTRIES];
   logic [RSP_PAYLOAD_WIDTH-1:0] payload_ff    [ENTRIES];
   logic [RSP_PAYLOAD_WIDTH-1:0] payload_in    [ENTRIES];

   logic tag_ok;
   logic bus_ok;

   always_comb begin
      busy_in       = busy_ff;
      src1_tag_in   = src1_tag_ff;
      src1_value_in = src1_value_ff;
      src2_tag_in   = src2_tag_ff;
      src2_value_in = src2_value_ff;
      payload_in    = payload_ff;

      tag_ok = (item.entry_tag != '0) && (item.entry_tag <= MAX_TAG);
      bus_ok = (item.bus_tag != '0);

      result = '0;

      case (item.op)
         OP_WRITE: begin
            result.accepted = tag_ok;
            for (int k = 0; k < ENTRIES; k++) begin
               if (item.entry_tag == RSP_TAG_WIDTH'(k + 1)) begin
                  busy_in[k]       = item.entry_busy;
                  src1_tag_in[k]   = item.entry_src1_tag;
                  src1_value_in[k] = item.entry_src1_value;
                  src2_tag_in[k]   = item.entry_src2_tag;
                  src2_value_in[k] = item.entry_src2_value;
                  payload_in[k]    = item.entry_payload;
               end
            end
         end
         OP_BROADCAST: begin
            for (int k = 0; k < ENTRIES; k++) begin
               if (bus_ok && busy_ff[k]) begin
                  if (src1_tag_ff[k] == item.bus_tag) begin
                     src1_tag_in[k]   = '0;
                     src1_value_in[k] = item.bus_value;
                  end
                  if (src2_tag_ff[k] == item.bus_tag) begin
                     src2_tag_in[k]   = '0;
                     src2_value_in[k] = item.bus_value;
                  end
               end
            end
         end
         OP_SELECT: begin
            for (int k = ENTRIES - 1; k >= 0; k--) begin
               if (busy_ff[k] && (src1_tag_ff[k] == '0) && (src2_tag_ff[k] == '0)) begin
                  result.accepted         = 1'b1;
                  result.ready_tag        = RSP_TAG_WIDTH'(k + 1);
                  result.ready_src1_value = src1_value_ff[k];
                  result.ready_src2_value = src2_value_ff[k];
                  result.ready_payload    = payload_ff[k];
               end
            end
         end
         default: begin
            result.accepted = tag_ok;
            for (int k = 0; k < ENTRIES; k++) begin
               if (item.entry_tag == RSP_TAG_WIDTH'(k + 1)) begin
                  busy_in[k] = 1'b0;
               end
            end
         end
      endcase

      result.all_empty = ~|busy_in;
      for (int k = ENTRIES - 1; k >= 0; k--) begin
         if (!busy_in[k]) begin
            result.free_tag = RSP_TAG_WIDTH'(k + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (item_valid) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_valid) begin
         src1_tag_ff   <= src1_tag_in;
         src1_value_ff <= src1_value_in;
         src2_tag_ff   <= src2_tag_in;
         src2_value_ff <= src2_value_in;
         payload_ff    <= payload_in;
      end
   end

endmodule
